// ----- rtl/core/bpc_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpc_pkg
// Shared constants, register indexes and press codes for the button press
// classifier.
// ----------------------------------------------------------------------------
package bpc_pkg;

	// Default sizes of the block.
	localparam int NUM_BUTTONS_DEF = 3;
	localparam int HOLD_WIDTH_DEF  = 16;

	// Field widths of the configuration registers.
	localparam int TIME_W     = 16;
	localparam int TICK_W     = 8;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 32;
	localparam int CODE_W     = 2;

	// Released ticks needed before a hold counts.
	localparam logic [1:0] COOL_TICKS = 2'd2;

	// Register values after reset.
	localparam logic [TICK_W-1:0] TICK_PERIOD_RST = 8'd20;
	localparam logic [TIME_W-1:0] SHORT_TIME_RST  = 16'd60;
	localparam logic [TIME_W-1:0] LONG_TIME_RST   = 16'd1000;
	localparam logic [TIME_W-1:0] BAND_TIME_RST   = 16'd100;

	// Configuration register indexes.
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_ACTIVE_LEVELS = 3'd0,
		CFG_TICK_PERIOD   = 3'd1,
		CFG_SHORT_TIME    = 3'd2,
		CFG_LONG_TIME     = 3'd3,
		CFG_BAND_TIME     = 3'd4
	} cfg_idx_t;

	// Per-button press codes.
	typedef enum logic [CODE_W-1:0] {
		CODE_NONE  = 2'd0,
		CODE_SHORT = 2'd1,
		CODE_LONG  = 2'd2
	} code_t;

endpackage

// ----- rtl/core/bpc_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Button press classifier channels
// Valid/ready channels for scan ticks, press codes and register writes.
// ----------------------------------------------------------------------------

// Scan tick channel: one sampled pin level per button.
interface bpc_pin_if import bpc_pkg::*; #(
	parameter int NUM_BUTTONS = NUM_BUTTONS_DEF
) ();
	logic                   valid;
	logic                   ready;
	logic [NUM_BUTTONS-1:0] pin_levels;

	modport source (output valid, output pin_levels, input ready);
	modport sink   (input valid, input pin_levels, output ready);
endinterface

// Result channel: two code bits per button.
interface bpc_code_if import bpc_pkg::*; #(
	parameter int NUM_BUTTONS = NUM_BUTTONS_DEF
) ();
	logic                            valid;
	logic                            ready;
	logic [CODE_W*NUM_BUTTONS-1:0]   press_codes;

	modport source (output valid, output press_codes, input ready);
	modport sink   (input valid, input press_codes, output ready);
endinterface

// Register write channel.
interface bpc_cfg_if import bpc_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  reg_index;
	logic [CFG_DATA_W-1:0] wr_data;

	modport source (output valid, output reg_index, output wr_data, input ready);
	modport sink   (input valid, input reg_index, input wr_data, output ready);
endinterface

// ----- rtl/core/button_press_classifier.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// button_press_classifier
// Short and long press detector. Per-button state lives in one memory that
// is read, updated and written back one button per cycle.
// ----------------------------------------------------------------------------
// Overlap: a new scan tick is accepted as the previous one issues its last state read,
// while fewer than two items are taken and not yet delivered; with fewer than three
// buttons the two-entry result queue can stall the input while the consumer is ready.
// Reset: registers return to their reset values and every state entry reads
// as zero through per-entry valid bits; no clearing pass is needed.
module button_press_classifier import bpc_pkg::*; #(
	parameter int NUM_BUTTONS = NUM_BUTTONS_DEF,
	parameter int HOLD_WIDTH  = HOLD_WIDTH_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	bpc_cfg_if.sink    cfg,
	bpc_pin_if.sink    in_ch,
	bpc_code_if.source out_ch
);

	localparam int BTN_W   = (NUM_BUTTONS > 1) ? $clog2(NUM_BUTTONS) : 1;
	localparam int CODES_W = CODE_W * NUM_BUTTONS;
	localparam int CMP_W   = (HOLD_WIDTH > TIME_W) ? HOLD_WIDTH : TIME_W;

	typedef struct packed {
		logic [1:0]            cool;
		logic [HOLD_WIDTH-1:0] hold;
		logic                  long_rep;
		code_t                 last;
	} entry_t;

	// Configuration registers.
	logic [NUM_BUTTONS-1:0] active_q;
	logic [TICK_W-1:0]      tick_q;
	logic [TIME_W-1:0]      short_q;
	logic [TIME_W-1:0]      long_q;
	logic [TIME_W-1:0]      band_q;

	// Sequencer.
	logic                   busy_q;
	logic [BTN_W-1:0]       btn_q;
	logic [NUM_BUTTONS-1:0] pins_q;
	logic [1:0]             pending_q;
	logic                   issue_last;
	logic                   in_acc;
	logic                   out_acc;

	// State memory and update stage.
	entry_t                 mem_q [NUM_BUTTONS];
	logic [NUM_BUTTONS-1:0] vld_q;
	entry_t                 rd_data_s1;
	logic                   rd_vld_s1;
	logic                   fwd_s1;
	entry_t                 fwd_data_s1;
	logic                   valid_s1;
	logic                   last_s1;
	logic [BTN_W-1:0]       btn_s1;
	logic                   pin_s1;

	entry_t                 cur;
	entry_t                 nxt;
	code_t                  code;
	logic [HOLD_WIDTH:0]    hold_sum;
	logic [HOLD_WIDTH-1:0]  hold_inc;
	logic [TIME_W-1:0]      short_lim;
	logic                   held;
	logic                   pressed;
	logic [CODES_W-1:0]     codes_q;
	logic [CODES_W-1:0]     codes_next;

	// Register writes are always taken.
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= '0;
			tick_q   <= TICK_PERIOD_RST;
			short_q  <= SHORT_TIME_RST;
			long_q   <= LONG_TIME_RST;
			band_q   <= BAND_TIME_RST;
		end else if (cfg.valid) begin
			unique case (cfg_idx_t'(cfg.reg_index))
				CFG_ACTIVE_LEVELS: active_q <= cfg.wr_data[NUM_BUTTONS-1:0];
				CFG_TICK_PERIOD:   tick_q   <= cfg.wr_data[TICK_W-1:0];
				CFG_SHORT_TIME:    short_q  <= cfg.wr_data[TIME_W-1:0];
				CFG_LONG_TIME:     long_q   <= cfg.wr_data[TIME_W-1:0];
				CFG_BAND_TIME:     band_q   <= cfg.wr_data[TIME_W-1:0];
				default: ;
			endcase
		end
	end

	// A new item enters when the sequencer is idle or as the previous one issues its last
	// read, as long as the result queue has room for every item still in flight.
	assign issue_last = busy_q && (btn_q == BTN_W'(NUM_BUTTONS - 1));
	assign in_ch.ready = (!busy_q || issue_last) && (pending_q < 2'd2);
	assign in_acc      = in_ch.valid && in_ch.ready;
	assign out_acc     = out_ch.valid && out_ch.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q    <= 1'b0;
			btn_q     <= '0;
			pending_q <= 2'd0;
		end else begin
			if (in_acc) begin
				busy_q <= 1'b1;
				btn_q  <= '0;
			end else if (issue_last) begin
				busy_q <= 1'b0;
			end else if (busy_q) begin
				btn_q <= btn_q + BTN_W'(1);
			end
			case ({in_acc, out_acc})
				2'b10:   pending_q <= pending_q + 2'd1;
				2'b01:   pending_q <= pending_q - 2'd1;
				default: pending_q <= pending_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			pins_q <= in_ch.pin_levels;
		end
	end

	// Read stage: fetch the entry of the current button. A write to the same
	// entry at this edge is forwarded.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= busy_q;
		end
	end

	always_ff @(posedge clk) begin
		if (busy_q) begin
			rd_data_s1  <= mem_q[btn_q];
			rd_vld_s1   <= vld_q[btn_q];
			fwd_s1      <= valid_s1 && (btn_s1 == btn_q);
			fwd_data_s1 <= nxt;
			btn_s1      <= btn_q;
			pin_s1      <= pins_q[btn_q];
			last_s1     <= issue_last;
		end
	end

	// Write back the updated entry.
	always_ff @(posedge clk) begin
		if (valid_s1) begin
			mem_q[btn_s1] <= nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (valid_s1) begin
			vld_q[btn_s1] <= 1'b1;
		end
	end

	// Entry update for one button.
	assign short_lim = (band_q > long_q) ? '0 : (long_q - band_q);
	assign hold_sum  = {1'b0, cur.hold} + (HOLD_WIDTH + 1)'(tick_q);
	assign hold_inc  = hold_sum[HOLD_WIDTH] ? '1 : hold_sum[HOLD_WIDTH-1:0];

	always_comb begin
		if (fwd_s1) begin
			cur = fwd_data_s1;
		end else if (rd_vld_s1) begin
			cur = rd_data_s1;
		end else begin
			cur = '0;
		end

		nxt     = cur;
		held    = (pin_s1 == active_q[btn_s1]);
		pressed = held && (cur.cool >= COOL_TICKS);
		if (!held && (cur.cool < COOL_TICKS)) begin
			nxt.cool = cur.cool + 2'd1;
		end

		if (pressed) begin
			nxt.hold = hold_inc;
			if (CMP_W'(hold_inc) >= CMP_W'(long_q)) begin
				code = cur.long_rep ? CODE_NONE : CODE_LONG;
				nxt.long_rep = 1'b1;
			end else begin
				code = cur.last;
			end
		end else begin
			if ((CMP_W'(cur.hold) >= CMP_W'(short_q)) &&
					(CMP_W'(cur.hold) < CMP_W'(short_lim))) begin
				code = CODE_SHORT;
			end else begin
				code = CODE_NONE;
			end
			nxt.long_rep = 1'b0;
			nxt.hold     = '0;
		end
		nxt.last = code;

		codes_next = codes_q;
		codes_next[{btn_s1, 1'b0} +: CODE_W] = code;
	end

	// Collect the codes of one item.
	always_ff @(posedge clk) begin
		if (valid_s1) begin
			codes_q <= codes_next;
		end
	end

	bpc_result_fifo #(
		.NUM_BUTTONS(NUM_BUTTONS)
	) u_result_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (valid_s1 && last_s1),
		.push_data(codes_next),
		.out_ch   (out_ch)
	);

endmodule

// ----- rtl/core/bpc_result_fifo.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpc_result_fifo
// Two-entry result queue that decouples the update pipeline from the
// consumer of press codes.
// ----------------------------------------------------------------------------
module bpc_result_fifo import bpc_pkg::*; #(
	parameter int NUM_BUTTONS = NUM_BUTTONS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          push,
	input  logic [CODE_W*NUM_BUTTONS-1:0] push_data,
	bpc_code_if.source                    out_ch
);

	localparam int WIDTH = CODE_W * NUM_BUTTONS;

	logic [WIDTH-1:0] slot_q [2];
	logic             wr_ptr_q;
	logic             rd_ptr_q;
	logic [1:0]       count_q;
	logic             pop;

	assign out_ch.valid       = (count_q != 2'd0);
	assign out_ch.press_codes = slot_q[rd_ptr_q];
	assign pop                = out_ch.valid && out_ch.ready;

	// Entry storage; the producer never pushes into a full queue.
	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_data;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// ----- rtl/core/bpc_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpc_checker
// Port-level checks of the button press classifier, bound to the top level.
// ----------------------------------------------------------------------------
module bpc_checker import bpc_pkg::*; #(
	parameter int NUM_BUTTONS = NUM_BUTTONS_DEF
) (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          in_valid,
	input logic                          in_ready,
	input logic                          out_valid,
	input logic                          out_ready,
	input logic [CODE_W*NUM_BUTTONS-1:0] press_codes
);

	logic [1:0]             pend_q;
	logic [NUM_BUTTONS-1:0] bad_code;

	// Items taken in and not yet delivered.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= 2'd0;
		end else begin
			case ({in_valid && in_ready, out_valid && out_ready})
				2'b10:   pend_q <= pend_q + 2'd1;
				2'b01:   pend_q <= pend_q - 2'd1;
				default: pend_q <= pend_q;
			endcase
		end
	end

	// Code 3 is never produced for any button.
	always_comb begin
		for (int i = 0; i < NUM_BUTTONS; i++) begin
			bad_code[i] = press_codes[CODE_W*i] & press_codes[CODE_W*i+1];
		end
	end

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result item dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(press_codes))
		else $error("result item changed while stalled");

	a_no_invented: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> pend_q != 2'd0)
		else $error("result item offered with no item pending");

	a_code_legal: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> bad_code == '0)
		else $error("illegal press code");

endmodule

bind button_press_classifier bpc_checker #(
	.NUM_BUTTONS(NUM_BUTTONS)
) u_bpc_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (in_ch.valid),
	.in_ready   (in_ch.ready),
	.out_valid  (out_ch.valid),
	.out_ready  (out_ch.ready),
	.press_codes(out_ch.press_codes)
);

// ----- dv/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Button press classifier testbench
// Sends scan ticks through the pin channel under several register settings
// and compares every press code item with a cycle-free model of the per-button
// cooldown, hold time and short/long press rules.
// ----------------------------------------------------------------------------
module tb_top;
	import bpc_pkg::*;

	localparam int NB          = NUM_BUTTONS_DEF;
	localparam int HW          = HOLD_WIDTH_DEF;
	localparam int DRAIN_TICKS = 20;
	localparam int MAX_REPORTS = 40;

	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	// Values driven onto the channels.
	logic                  tick_valid = 1'b0;
	logic [NB-1:0]         tick_pins  = '0;
	logic                  code_ready = 1'b0;
	logic                  wr_valid   = 1'b0;
	cfg_idx_t              wr_index   = CFG_ACTIVE_LEVELS;
	logic [CFG_DATA_W-1:0] wr_value   = '0;

	bpc_pin_if  #(.NUM_BUTTONS(NB)) pin_bus ();
	bpc_code_if #(.NUM_BUTTONS(NB)) code_bus ();
	bpc_cfg_if                      cfg_bus ();

	assign pin_bus.valid      = tick_valid;
	assign pin_bus.pin_levels = tick_pins;
	assign code_bus.ready     = code_ready;
	assign cfg_bus.valid      = wr_valid;
	assign cfg_bus.reg_index  = wr_index;
	assign cfg_bus.wr_data    = wr_value;

	button_press_classifier #(
		.NUM_BUTTONS(NB),
		.HOLD_WIDTH (HW)
	) i_dut (
		.clk   (clk),
		.arst_n(arst_n),
		.cfg   (cfg_bus),
		.in_ch (pin_bus),
		.out_ch(code_bus)
	);

	// Model copy of the registers.
	logic [NB-1:0]     act_lv;
	logic [TICK_W-1:0] period;
	logic [TIME_W-1:0] t_short;
	logic [TIME_W-1:0] t_long;
	logic [TIME_W-1:0] t_band;

	// Model copy of the per-button state.
	logic [1:0]    cool     [NB];
	logic [HW-1:0] hold     [NB];
	logic          pressed  [NB];
	logic          long_rep [NB];
	code_t         last     [NB];

	logic [NB-1:0]        pending_ticks  [$];
	logic [CODE_W*NB-1:0] expected_codes [$];

	int ticks_sent = 0;
	int fail_count = 0;

	// Stimulus run state per button: held or released, and ticks left in the run.
	logic run_held [NB];
	int   run_left [NB];

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Computes the press codes of one scan tick and advances the model state.
	function automatic logic [CODE_W*NB-1:0] classify_tick(input logic [NB-1:0] pins);
		logic [CODE_W*NB-1:0] codes;
		logic [HW:0]          sum;
		logic [TIME_W-1:0]    short_lim;
		code_t                code;
		codes     = '0;
		short_lim = (t_band > t_long) ? '0 : t_long - t_band;
		for (int i = 0; i < NB; i++) begin
			if (pins[i] == act_lv[i]) begin
				if (cool[i] >= COOL_TICKS) begin
					sum = {1'b0, hold[i]} + (HW + 1)'(period);
					hold[i]    = sum[HW] ? {HW{1'b1}} : sum[HW-1:0];
					pressed[i] = 1'b1;
				end else begin
					pressed[i] = 1'b0;
				end
			end else begin
				pressed[i] = 1'b0;
				if (cool[i] < COOL_TICKS)
					cool[i] = cool[i] + 2'd1;
			end

			if (pressed[i]) begin
				if (hold[i] >= t_long) begin
					code        = long_rep[i] ? CODE_NONE : CODE_LONG;
					long_rep[i] = 1'b1;
				end else begin
					code = last[i];
				end
			end else begin
				code        = (hold[i] >= t_short && hold[i] < short_lim) ? CODE_SHORT : CODE_NONE;
				long_rep[i] = 1'b0;
				hold[i]     = '0;
			end
			last[i]               = code;
			codes[CODE_W*i +: CODE_W] = code;
		end
		return codes;
	endfunction

	// Driver: offers pending scan ticks and predicts each accepted item.
	always @(posedge clk) begin
		logic quiet;
		quiet = (ticks_sent >= 500 && ticks_sent < 750);
		if (tick_valid && pin_bus.ready) begin
			expected_codes.push_back(classify_tick(tick_pins));
			ticks_sent <= ticks_sent + 1;
		end
		if (!tick_valid || pin_bus.ready) begin
			if (pending_ticks.size() > 0 && (quiet || $urandom_range(0, 99) >= 30)) begin
				tick_valid <= 1'b1;
				tick_pins  <= pending_ticks.pop_front();
			end else begin
				tick_valid <= 1'b0;
			end
		end
	end

	// Receiver: random back-pressure, one long hold-off, and the result check.
	always @(posedge clk) begin
		static int  hold_off   = 0;
		static bit  stall_done = 0;
		logic [CODE_W*NB-1:0] want;
		if (code_bus.valid && code_ready) begin
			if (expected_codes.size() == 0) begin
				fail_count++;
				if (fail_count <= MAX_REPORTS)
					$display("%0t: unexpected item, press_codes actual %h", $time,
						code_bus.press_codes);
			end else begin
				want = expected_codes.pop_front();
				if (code_bus.press_codes !== want) begin
					fail_count++;
					if (fail_count <= MAX_REPORTS)
						$display("%0t: press_codes mismatch, expected %h actual %h", $time,
							want, code_bus.press_codes);
				end
			end
		end

		if (hold_off > 0) begin
			hold_off--;
			code_ready <= 1'b0;
		end else if (!stall_done && ticks_sent >= 300) begin
			stall_done = 1;
			hold_off   = 150;
			code_ready <= 1'b0;
		end else begin
			code_ready <= (ticks_sent >= 500 && ticks_sent < 750) ||
				($urandom_range(0, 99) >= 30);
		end
	end

	// Writes one register; called right after a rising edge, leaves valid high.
	task automatic cfg_write(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] value);
		wr_valid <= 1'b1;
		wr_index <= idx;
		wr_value <= value;
		@(posedge clk);
		while (!cfg_bus.ready)
			@(posedge clk);
		case (idx)
			CFG_ACTIVE_LEVELS: act_lv  = value[NB-1:0];
			CFG_TICK_PERIOD:   period  = value[TICK_W-1:0];
			CFG_SHORT_TIME:    t_short = value[TIME_W-1:0];
			CFG_LONG_TIME:     t_long  = value[TIME_W-1:0];
			CFG_BAND_TIME:     t_band  = value[TIME_W-1:0];
			default: ;
		endcase
	endtask

	task automatic set_config(input int act, input int tick, input int shrt, input int lng,
			input int band);
		cfg_write(CFG_ACTIVE_LEVELS, act);
		cfg_write(CFG_TICK_PERIOD, tick);
		cfg_write(CFG_SHORT_TIME, shrt);
		cfg_write(CFG_LONG_TIME, lng);
		cfg_write(CFG_BAND_TIME, band);
		wr_valid <= 1'b0;
		@(posedge clk);
	endtask

	// Waits until every tick is sent and every press code item has arrived.
	task automatic wait_drained();
		while (pending_ticks.size() > 0 || tick_valid || expected_codes.size() > 0)
			@(posedge clk);
		repeat (DRAIN_TICKS) @(posedge clk);
	endtask

	// Queues press/release runs per button, sized around the current thresholds.
	task automatic queue_ticks(input int count);
		int            lim;
		logic [NB-1:0] pins;
		lim = int'(t_long) / int'(period) + 3;
		if (lim > 300)
			lim = 300;
		repeat (count) begin
			for (int i = 0; i < NB; i++) begin
				if (run_left[i] == 0) begin
					run_held[i] = !run_held[i];
					if (!run_held[i])
						run_left[i] = $urandom_range(1, 4);
					else if ($urandom_range(0, 99) < 85)
						run_left[i] = $urandom_range(1, lim);
					else
						run_left[i] = $urandom_range(1, 300);
				end
				run_left[i]--;
				pins[i] = run_held[i] ? act_lv[i] : !act_lv[i];
			end
			if ($urandom_range(0, 99) < 12)
				pins = NB'($urandom_range(0, (1 << NB) - 1));
			pending_ticks.push_back(pins);
		end
	endtask

	initial begin
		int lng;
		act_lv  = '0;
		period  = TICK_PERIOD_RST;
		t_short = SHORT_TIME_RST;
		t_long  = LONG_TIME_RST;
		t_band  = BAND_TIME_RST;
		for (int i = 0; i < NB; i++) begin
			cool[i]     = '0;
			hold[i]     = '0;
			pressed[i]  = 1'b0;
			long_rep[i] = 1'b0;
			last[i]     = CODE_NONE;
			run_held[i] = 1'b0;
			run_left[i] = 0;
		end

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset settings, pin low means pressed. Buttons held right after reset
		// sit in cooldown and count as released.
		pending_ticks.push_back(3'b000);
		pending_ticks.push_back(3'b000);
		pending_ticks.push_back(3'b111);
		// Button 1 held with one cooldown tick done: still released.
		pending_ticks.push_back(3'b101);
		pending_ticks.push_back(3'b111);
		pending_ticks.push_back(3'b111);
		// Three held ticks reach the short minimum exactly, then release.
		repeat (3) pending_ticks.push_back(3'b000);
		pending_ticks.push_back(3'b111);
		// Too short a hold on button 0, mixed levels on the others.
		repeat (2) pending_ticks.push_back(3'b110);
		pending_ticks.push_back(3'b011);
		pending_ticks.push_back(3'b111);
		pending_ticks.push_back(3'b100);
		pending_ticks.push_back(3'b001);
		pending_ticks.push_back(3'b111);
		queue_ticks(180);
		wait_drained();

		// Smallest tick period with tiny thresholds and a zero short minimum.
		set_config(3'b101, 1, 0, 5, 2);
		queue_ticks(200);
		wait_drained();

		// Largest values: hold time saturates and only then reports long.
		set_config(3'b111, 255, 65535, 65535, 0);
		queue_ticks(200);
		wait_drained();

		// Guard band above the long threshold: no short press possible.
		set_config(3'b010, 10, 0, 30, 40);
		queue_ticks(200);
		wait_drained();

		// Zero long threshold: every counted hold is long at once.
		set_config(3'b000, 3, 5, 0, 0);
		queue_ticks(150);
		wait_drained();

		// Moderate random settings.
		lng = $urandom_range(0, 600);
		set_config($urandom_range(0, 7), $urandom_range(1, 50), $urandom_range(0, lng),
			lng, $urandom_range(0, lng));
		queue_ticks(200);
		wait_drained();

		// Coarse tick period with random wide thresholds.
		set_config($urandom_range(0, 7), $urandom_range(100, 255), $urandom_range(0, 65535),
			$urandom_range(0, 65535), $urandom_range(0, 65535));
		queue_ticks(150);
		wait_drained();

		// Widest guard band against the largest long threshold.
		set_config(3'b110, 20, 0, 65535, 65535);
		queue_ticks(100);
		wait_drained();

		if (fail_count == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

	initial begin
		#400000;
		$display("RESULT: ERROR");
		$finish;
	end

endmodule
